>>> rtl/core/dpe_pkg.sv
// Shared types and codes for the data-processing execute pipeline.
`timescale 1ns / 1ps

package dpe_pkg;

	// Width of the datapath.
	localparam int unsigned DataW = 32;

	// Data-processing opcodes handled by the block; all other codes are invalid.
	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13
	} opcode_t;

	// Shift types of the operand2 register form.
	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_kind_t;

	// One instruction as it arrives at the block.
	typedef struct packed {
		logic [3:0]       opcode;
		logic             imm_flag;
		logic             set_flags;
		logic [11:0]      operand2;
		logic [DataW-1:0] rn_value;
		logic [DataW-1:0] rm_value;
		logic [7:0]       rs_value;
		logic             old_v;
	} instr_t;

	// After decode: what the shifter must do, plus what the ALU needs later.
	typedef struct packed {
		logic [3:0]       opcode;
		logic             set_flags;
		logic             old_v;
		logic [DataW-1:0] rn_value;
		shift_kind_t      kind;
		logic [7:0]       amount;
		logic [DataW-1:0] value;
	} dec_t;

	// After the shifter: the finished second operand and its carry.
	typedef struct packed {
		logic [3:0]       opcode;
		logic             set_flags;
		logic             old_v;
		logic [DataW-1:0] rn_value;
		logic [DataW-1:0] op2;
		logic             shift_carry;
	} shf_t;

	// ALU outcome held in the output register.
	typedef struct packed {
		logic [DataW-1:0] result;
		logic             write_result;
		logic             flags_update;
		logic             flag_c;
		logic             flag_v;
		logic             invalid_opcode;
	} alu_res_t;

endpackage

>>> rtl/core/dpe_if.sv
// Request channel interfaces for instructions in and results out.
`timescale 1ns / 1ps

interface dpe_instr_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic        imm_flag;
	logic        set_flags;
	logic [11:0] operand2;
	logic [31:0] rn_value;
	logic [31:0] rm_value;
	logic [7:0]  rs_value;
	logic        old_v;

	modport source (
		output valid, opcode, imm_flag, set_flags, operand2, rn_value, rm_value,
		       rs_value, old_v,
		input  ready
	);
	modport sink (
		input  valid, opcode, imm_flag, set_flags, operand2, rn_value, rm_value,
		       rs_value, old_v,
		output ready
	);
endinterface

interface dpe_resp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;
	logic        write_result;
	logic        flags_update;
	logic        flag_n;
	logic        flag_z;
	logic        flag_c;
	logic        flag_v;
	logic        invalid_opcode;

	modport source (
		output valid, result, write_result, flags_update, flag_n, flag_z, flag_c,
		       flag_v, invalid_opcode,
		input  ready
	);
	modport sink (
		input  valid, result, write_result, flags_update, flag_n, flag_z, flag_c,
		       flag_v, invalid_opcode,
		output ready
	);
endinterface

>>> rtl/core/dpe_decode.sv
// First pipeline stage: decodes operand2 into a shift type, amount and value.
`timescale 1ns / 1ps

module dpe_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	output logic           ready_o,
	input  dpe_pkg::instr_t instr_i,
	output logic           valid_o,
	input  logic           ready_i,
	output dpe_pkg::dec_t  dec_o
);
	import dpe_pkg::*;

	dec_t dec_d;
	dec_t dec_s1;
	logic valid_s1;

	// The stage takes a new request when it is empty or its contents move on.
	assign ready_o = !valid_s1 || ready_i;

	// Select immediate rotation or register shift parameters.
	always_comb begin
		dec_d.opcode    = instr_i.opcode;
		dec_d.set_flags = instr_i.set_flags;
		dec_d.old_v     = instr_i.old_v;
		dec_d.rn_value  = instr_i.rn_value;
		if (instr_i.imm_flag) begin
			dec_d.kind   = SH_ROR;
			dec_d.amount = {3'b000, instr_i.operand2[11:8], 1'b0};
			dec_d.value  = {{(DataW-8){1'b0}}, instr_i.operand2[7:0]};
		end else begin
			dec_d.kind   = shift_kind_t'(instr_i.operand2[6:5]);
			dec_d.amount = instr_i.operand2[4] ? instr_i.rs_value
			                                   : {3'b000, instr_i.operand2[11:7]};
			dec_d.value  = instr_i.rm_value;
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_o) begin
			valid_s1 <= valid_i;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			dec_s1 <= dec_d;
		end
	end

	assign valid_o = valid_s1;
	assign dec_o   = dec_s1;

endmodule

>>> rtl/core/dpe_shift.sv
// Second pipeline stage: barrel shifter producing operand2 and the shifter carry.
`timescale 1ns / 1ps

module dpe_shift (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_i,
	output logic          ready_o,
	input  dpe_pkg::dec_t dec_i,
	output logic          valid_o,
	input  logic          ready_i,
	output dpe_pkg::shf_t shf_o
);
	import dpe_pkg::*;

	shf_t             shf_d;
	shf_t             shf_s2;
	logic             valid_s2;
	logic [4:0]       sh;
	logic             big;
	logic [DataW:0]   lsl_ext;
	logic [DataW:0]   lsr_ext;
	logic [DataW:0]   asr_ext;
	logic [2*DataW-1:0] ror_ext;
	logic [DataW-1:0] ror_val;
	logic [DataW-1:0] op2;
	logic             carry;

	assign ready_o = !valid_s2 || ready_i;

	// Shifts by the low five bits; the carry bit rides in one extra position.
	assign sh      = dec_i.amount[4:0];
	assign big     = |dec_i.amount[7:5];
	assign lsl_ext = {1'b0, dec_i.value} << sh;
	assign lsr_ext = {dec_i.value, 1'b0} >> sh;
	assign asr_ext = $unsigned($signed({dec_i.value, 1'b0}) >>> sh);
	assign ror_ext = {dec_i.value, dec_i.value} >> sh;
	assign ror_val = ror_ext[DataW-1:0];

	// Pick the result per shift type, covering zero and out-of-range amounts.
	always_comb begin
		op2   = dec_i.value;
		carry = 1'b0;
		if (dec_i.amount != 8'd0) begin
			unique case (dec_i.kind)
				SH_LSL: begin
					if (!big) begin
						op2   = lsl_ext[DataW-1:0];
						carry = lsl_ext[DataW];
					end else begin
						op2   = '0;
						carry = (dec_i.amount == 8'd32) ? dec_i.value[0] : 1'b0;
					end
				end
				SH_LSR: begin
					if (!big) begin
						op2   = lsr_ext[DataW:1];
						carry = lsr_ext[0];
					end else begin
						op2   = '0;
						carry = (dec_i.amount == 8'd32) ? dec_i.value[DataW-1] : 1'b0;
					end
				end
				SH_ASR: begin
					if (!big) begin
						op2   = asr_ext[DataW:1];
						carry = asr_ext[0];
					end else begin
						op2   = {DataW{dec_i.value[DataW-1]}};
						carry = dec_i.value[DataW-1];
					end
				end
				SH_ROR: begin
					op2   = ror_val;
					carry = ror_val[DataW-1];
				end
			endcase
		end
	end

	always_comb begin
		shf_d.opcode      = dec_i.opcode;
		shf_d.set_flags   = dec_i.set_flags;
		shf_d.old_v       = dec_i.old_v;
		shf_d.rn_value    = dec_i.rn_value;
		shf_d.op2         = op2;
		shf_d.shift_carry = carry;
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_o) begin
			valid_s2 <= valid_i;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			shf_s2 <= shf_d;
		end
	end

	assign valid_o = valid_s2;
	assign shf_o   = shf_s2;

endmodule

>>> rtl/core/dpe_alu.sv
// Third pipeline stage: ALU operation and carry, held in the output register.
`timescale 1ns / 1ps

module dpe_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_i,
	output logic              ready_o,
	input  dpe_pkg::shf_t     shf_i,
	output logic              valid_o,
	input  logic              ready_i,
	output dpe_pkg::alu_res_t res_o
);
	import dpe_pkg::*;

	alu_res_t       res_d;
	alu_res_t       res_s3;
	logic           valid_s3;
	logic [DataW:0] sum;
	logic [DataW:0] diff_nm;
	logic [DataW:0] diff_mn;

	assign ready_o = !valid_s3 || ready_i;

	// Adder and the two subtractors; bit DataW is carry or borrow.
	assign sum     = {1'b0, shf_i.rn_value} + {1'b0, shf_i.op2};
	assign diff_nm = {1'b0, shf_i.rn_value} - {1'b0, shf_i.op2};
	assign diff_mn = {1'b0, shf_i.op2} - {1'b0, shf_i.rn_value};

	// Operation select; an unknown opcode leaves every field clear but the error bit.
	always_comb begin
		res_d.result         = '0;
		res_d.write_result   = 1'b1;
		res_d.flags_update   = shf_i.set_flags;
		res_d.flag_c         = shf_i.shift_carry;
		res_d.flag_v         = shf_i.old_v;
		res_d.invalid_opcode = 1'b0;
		unique case (shf_i.opcode)
			OP_AND: res_d.result = shf_i.rn_value & shf_i.op2;
			OP_TST: begin
				res_d.result       = shf_i.rn_value & shf_i.op2;
				res_d.write_result = 1'b0;
			end
			OP_EOR: res_d.result = shf_i.rn_value ^ shf_i.op2;
			OP_TEQ: begin
				res_d.result       = shf_i.rn_value ^ shf_i.op2;
				res_d.write_result = 1'b0;
			end
			OP_SUB: begin
				res_d.result = diff_nm[DataW-1:0];
				res_d.flag_c = !diff_nm[DataW];
			end
			OP_CMP: begin
				res_d.result       = diff_nm[DataW-1:0];
				res_d.flag_c       = !diff_nm[DataW];
				res_d.write_result = 1'b0;
			end
			OP_RSB: begin
				res_d.result = diff_mn[DataW-1:0];
				res_d.flag_c = !diff_mn[DataW];
			end
			OP_ADD: begin
				res_d.result = sum[DataW-1:0];
				res_d.flag_c = sum[DataW];
			end
			OP_ORR: res_d.result = shf_i.rn_value | shf_i.op2;
			OP_MOV: res_d.result = shf_i.op2;
			default: begin
				res_d.write_result   = 1'b0;
				res_d.flags_update   = 1'b0;
				res_d.flag_c         = 1'b0;
				res_d.flag_v         = 1'b0;
				res_d.invalid_opcode = 1'b1;
			end
		endcase
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_o) begin
			valid_s3 <= valid_i;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			res_s3 <= res_d;
		end
	end

	assign valid_o = valid_s3;
	assign res_o   = res_s3;

endmodule

>>> rtl/core/arm_data_processing_execute_top.sv
// Top level of the data-processing execute pipeline.
// Usage:
//   The instr channel takes one data-processing instruction per request:
//   opcode, operand2 field, the first operand and the register values the
//   shifter needs, plus the current overflow flag. The resp channel returns
//   one result per instruction, in order: the 32-bit result, write and flag
//   update enables, N, Z, C, V and an invalid-opcode flag.
//   The pipeline has three register stages (decode, barrel shifter, ALU). An
//   instruction accepted into the decode register passes the shifter and ALU
//   registers before it is offered as a result. One instruction can enter
//   every cycle while the receiver takes results; throughput is one per
//   cycle, set by the shifter and the 33-bit adder each having a stage of
//   their own. Each stage holds its request while the stage after it cannot
//   take it, and an empty stage always takes a new one, so gaps are squeezed
//   out while the receiver stalls, and up to three are held in flight.
//   Reset clears all stage valid bits; the pipeline is then empty and ready.
`timescale 1ns / 1ps

module arm_data_processing_execute_top (
	input  logic    clk,
	input  logic    arst_n,
	dpe_instr_if.sink   instr,
	dpe_resp_if.source  resp
);
	import dpe_pkg::*;

	instr_t   instr_pl;
	dec_t     dec;
	shf_t     shf;
	alu_res_t res;
	logic     dec_valid;
	logic     dec_ready;
	logic     shf_valid;
	logic     shf_ready;

	// Gather the instruction fields.
	always_comb begin
		instr_pl.opcode    = instr.opcode;
		instr_pl.imm_flag  = instr.imm_flag;
		instr_pl.set_flags = instr.set_flags;
		instr_pl.operand2  = instr.operand2;
		instr_pl.rn_value  = instr.rn_value;
		instr_pl.rm_value  = instr.rm_value;
		instr_pl.rs_value  = instr.rs_value;
		instr_pl.old_v     = instr.old_v;
	end

	dpe_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (instr.valid),
		.ready_o (instr.ready),
		.instr_i (instr_pl),
		.valid_o (dec_valid),
		.ready_i (dec_ready),
		.dec_o   (dec)
	);

	dpe_shift u_shift (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (dec_valid),
		.ready_o (dec_ready),
		.dec_i   (dec),
		.valid_o (shf_valid),
		.ready_i (shf_ready),
		.shf_o   (shf)
	);

	dpe_alu u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (shf_valid),
		.ready_o (shf_ready),
		.shf_i   (shf),
		.valid_o (resp.valid),
		.ready_i (resp.ready),
		.res_o   (res)
	);

	// Result fields; N and Z come from the registered result, Z held low for an invalid opcode.
	assign resp.result         = res.result;
	assign resp.write_result   = res.write_result;
	assign resp.flags_update   = res.flags_update;
	assign resp.flag_n         = res.result[DataW-1];
	assign resp.flag_z         = !res.invalid_opcode && (res.result == '0);
	assign resp.flag_c         = res.flag_c;
	assign resp.flag_v         = res.flag_v;
	assign resp.invalid_opcode = res.invalid_opcode;

	// The input can only be held off when the whole pipeline is full and stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!instr.ready |-> (resp.valid && !resp.ready && shf_valid && dec_valid))
		else $error("input stalled while the pipeline has room");

	// An invalid opcode must neither write nor update flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		(resp.valid && resp.invalid_opcode) |->
		(!resp.write_result && !resp.flags_update && (resp.result == '0) && !resp.flag_c))
		else $error("invalid opcode produced side effects");

	// A request accepted into an empty, free-running pipeline is offered as a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(instr.valid && instr.ready && resp.ready) ##1 resp.ready ##1 resp.ready
		|=> resp.valid)
		else $error("result lost in the pipeline");

endmodule
